[rtl/core/rbes_pkg.sv]
// Shared types, command codes and saturating helpers for the rigid body step block.
`default_nettype none
package rbes_pkg;

  localparam int MAX_OBJECTS = 16;
  localparam int MAX_PLANES  = 8;
  localparam int FRAC_BITS   = 16;
  localparam int OBJ_W       = 4;
  localparam int PLANE_W     = 3;
  localparam int CFG_IDX_W   = 3;

  typedef logic signed [31:0] q_t;
  typedef q_t [2:0] vec3_t;

  localparam logic [2:0] CMD_SET_POS   = 3'd0;
  localparam logic [2:0] CMD_SET_VEL   = 3'd1;
  localparam logic [2:0] CMD_BOX_LO    = 3'd2;
  localparam logic [2:0] CMD_BOX_HI    = 3'd3;
  localparam logic [2:0] CMD_SET_FORCE = 3'd4;
  localparam logic [2:0] CMD_ADD_ACC   = 3'd5;
  localparam logic [2:0] CMD_SET_PLANE = 3'd6;
  localparam logic [2:0] CMD_STEP      = 3'd7;

  localparam logic [CFG_IDX_W-1:0] CFG_GRAV_X    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_GRAV_Y    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_GRAV_Z    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_TIME_STEP = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_SCALE     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_OBJ_CNT   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_PLANE_CNT = 3'd6;

  typedef struct packed {
    logic [2:0]       cmd;
    logic [OBJ_W-1:0] index;
    vec3_t            vec;
    q_t               scalar;
  } cmd_t;

  function automatic q_t sat32(input logic signed [63:0] v);
    q_t r;
    if (v > 64'sd2147483647) r = 32'sh7fffffff;
    else if (v < -64'sd2147483648) r = 32'sh80000000;
    else r = v[31:0];
    return r;
  endfunction

  function automatic q_t sadd(input q_t a, input q_t b);
    logic signed [63:0] s;
    s = {{32{a[31]}}, a} + {{32{b[31]}}, b};
    return sat32(s);
  endfunction

  function automatic q_t ssub(input q_t a, input q_t b);
    logic signed [63:0] s;
    s = {{32{a[31]}}, a} - {{32{b[31]}}, b};
    return sat32(s);
  endfunction

endpackage
`default_nettype wire

[rtl/core/rbes_front.sv]
// Front end: accepts command beats, drops out-of-table plane writes, queues the rest.
`default_nettype none
module rbes_front
  import rbes_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire logic [2:0]       in_cmd,
  input  wire logic [OBJ_W-1:0] in_index,
  input  wire q_t               in_vec_x,
  input  wire q_t               in_vec_y,
  input  wire q_t               in_vec_z,
  input  wire q_t               in_scalar,
  output logic                  q_valid,
  input  wire logic             q_ready,
  output cmd_t                  q_cmd
);

  localparam int QDEPTH = 2;

  cmd_t       mem_r [QDEPTH];
  logic       wr_ptr_r, rd_ptr_r;
  logic [1:0] cnt_r, cnt_nxt;
  logic       keep, push, pop;
  cmd_t       beat;

  assign keep     = (in_cmd != CMD_SET_PLANE) || (in_index < OBJ_W'(MAX_PLANES));
  assign in_ready = (cnt_r != 2'(QDEPTH));
  assign push     = in_valid && in_ready && keep;
  assign q_valid  = (cnt_r != 2'd0);
  assign pop      = q_valid && q_ready;
  assign q_cmd    = mem_r[rd_ptr_r];
  assign cnt_nxt  = cnt_r + {1'b0, push} - {1'b0, pop};

  always_comb begin
    beat.cmd    = in_cmd;
    beat.index  = in_index;
    beat.vec    = {in_vec_z, in_vec_y, in_vec_x};
    beat.scalar = in_scalar;
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wr_ptr_r] <= beat;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      if (push) wr_ptr_r <= ~wr_ptr_r;
      if (pop) rd_ptr_r <= ~rd_ptr_r;
      cnt_r <= cnt_nxt;
    end
  end

endmodule
`default_nettype wire

[rtl/core/rbes_div.sv]
// Radix-2 signed divider, 64 by 32 bits, truncating, saturated to 32 bits; zero divisor gives 0.
`default_nettype none
module rbes_div
  import rbes_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  input  wire logic signed [63:0] dvd,
  input  wire q_t                 dsr,
  output logic                    busy,
  output logic                    done,
  output q_t                      quot
);

  logic        busy_r, done_r, neg_r;
  logic [6:0]  cnt_r;
  logic [63:0] dvd_r;
  logic [31:0] rem_r, dsr_r;
  q_t          quot_r;
  logic [63:0] dvd_abs;
  logic [31:0] dsr_abs;
  logic [32:0] sh;
  logic        qbit;

  assign dvd_abs = dvd[63] ? 64'(-dvd) : 64'(dvd);
  assign dsr_abs = dsr[31] ? 32'(-dsr) : 32'(dsr);
  assign sh      = {rem_r, dvd_r[63]};
  assign qbit    = (sh >= {1'b0, dsr_r});
  assign busy    = busy_r;
  assign done    = done_r;
  assign quot    = quot_r;

  always_ff @(posedge clk) begin
    if (start) begin
      neg_r <= dvd[63] ^ dsr[31];
      dvd_r <= dvd_abs;
      dsr_r <= dsr_abs;
      rem_r <= '0;
      if (dsr == '0) quot_r <= '0;
    end else if (busy_r && cnt_r != 7'd0) begin
      rem_r <= qbit ? 32'(sh - {1'b0, dsr_r}) : sh[31:0];
      dvd_r <= {dvd_r[62:0], qbit};
    end else if (busy_r) begin
      if (neg_r) quot_r <= (dvd_r > 64'h8000_0000) ? 32'sh80000000 : q_t'(-dvd_r[31:0]);
      else       quot_r <= (dvd_r > 64'h7fff_ffff) ? 32'sh7fffffff : q_t'(dvd_r[31:0]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        if (dsr == '0) begin
          done_r <= 1'b1;
        end else begin
          busy_r <= 1'b1;
          cnt_r  <= 7'd64;
        end
      end else if (busy_r && cnt_r != 7'd0) begin
        cnt_r <= cnt_r - 7'd1;
      end else if (busy_r) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

endmodule
`default_nettype wire

[rtl/core/rbes_back.sv]
// Back end: object and plane tables, config registers, step sequencer and result register.
`default_nettype none
module rbes_back
  import rbes_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [31:0]          cfg_data,
  input  wire logic                 q_valid,
  output logic                      q_ready,
  input  wire cmd_t                 q_cmd,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output logic [OBJ_W-1:0]          out_object_index,
  output vec3_t                     out_pos,
  output logic                      out_blocked,
  output logic                      out_last
);

  localparam int ACC_W = 51;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_FMUL  = 4'd1;
  localparam logic [3:0] S_FADD  = 4'd2;
  localparam logic [3:0] S_ADIV  = 4'd3;
  localparam logic [3:0] S_AWAIT = 4'd4;
  localparam logic [3:0] S_VEL   = 4'd5;
  localparam logic [3:0] S_MMUL  = 4'd6;
  localparam logic [3:0] S_MDIV  = 4'd7;
  localparam logic [3:0] S_MWAIT = 4'd8;
  localparam logic [3:0] S_MPOS  = 4'd9;
  localparam logic [3:0] S_CORN  = 4'd10;
  localparam logic [3:0] S_DMUL  = 4'd11;
  localparam logic [3:0] S_DACC  = 4'd12;
  localparam logic [3:0] S_OUT   = 4'd13;

  vec3_t pos_r [MAX_OBJECTS];
  vec3_t vel_r [MAX_OBJECTS];
  vec3_t frc_r [MAX_OBJECTS];
  q_t    mass_r [MAX_OBJECTS];
  vec3_t blo_r [MAX_OBJECTS];
  vec3_t bhi_r [MAX_OBJECTS];
  vec3_t nrm_r [MAX_PLANES];
  q_t    off_r [MAX_PLANES];

  vec3_t       grav_r;
  logic [30:0] ts_r, scale_r;
  logic [4:0]  ocnt_r;
  logic [3:0]  pcnt_r;

  logic [3:0]         st_r, st_nxt;
  logic [1:0]         ax_r, ax_nxt;
  logic [OBJ_W-1:0]   obj_r, obj_nxt;
  logic [PLANE_W-1:0] pl_r, pl_nxt;
  logic [2:0]         crn_r, crn_nxt;
  logic               blk_r, blk_nxt;

  cmd_t                   cmd_r;
  logic signed [63:0]     prod_r, prod_sh;
  logic signed [ACC_W-1:0] acc_r, acc_sum, off_ext;
  vec3_t                  mv_r, lo_r, hi_r;

  logic             out_valid_r, out_blk_r, out_last_r;
  logic [OBJ_W-1:0] out_idx_r;
  vec3_t            out_pos_r;

  logic [4:0]         n_w;
  logic [3:0]         np_w;
  logic               obj_last, pl_last, pop, out_load, hit;
  logic               div_start, div_busy, div_done;
  logic signed [63:0] div_dvd;
  q_t                 div_dsr, div_q, corner, vel_new, frc_old, div_force;

  assign n_w      = (ocnt_r > 5'(MAX_OBJECTS)) ? 5'(MAX_OBJECTS) : ocnt_r;
  assign np_w     = (pcnt_r > 4'(MAX_PLANES)) ? 4'(MAX_PLANES) : pcnt_r;
  assign obj_last = (({1'b0, obj_r} + 5'd1) == n_w);
  assign pl_last  = (({1'b0, pl_r} + 4'd1) == np_w);
  assign q_ready  = (st_r == S_IDLE);
  assign pop      = q_valid && q_ready;
  assign prod_sh  = prod_r >>> FRAC_BITS;
  assign acc_sum  = acc_r + prod_sh[ACC_W-1:0];
  assign off_ext  = {{(ACC_W-32){off_r[pl_r][31]}}, off_r[pl_r]};
  assign corner   = crn_r[ax_r] ? hi_r[ax_r] : lo_r[ax_r];
  assign vel_new  = sadd(vel_r[obj_r][ax_r], sadd(div_q, grav_r[ax_r]));
  assign frc_old  = frc_r[obj_r][ax_r];
  assign div_force = frc_old;

  rbes_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .dvd   (div_dvd),
    .dsr   (div_dsr),
    .busy  (div_busy),
    .done  (div_done),
    .quot  (div_q)
  );

  always_comb begin
    st_nxt    = st_r;
    ax_nxt    = ax_r;
    obj_nxt   = obj_r;
    pl_nxt    = pl_r;
    crn_nxt   = crn_r;
    blk_nxt   = blk_r;
    div_start = 1'b0;
    div_dvd   = '0;
    div_dsr   = '0;
    out_load  = 1'b0;
    hit       = 1'b0;
    case (st_r)
      S_IDLE: if (pop) begin
        if (q_cmd.cmd == CMD_ADD_ACC) begin
          ax_nxt = 2'd0;
          st_nxt = S_FMUL;
        end else if (q_cmd.cmd == CMD_STEP && n_w != 5'd0) begin
          obj_nxt = '0;
          ax_nxt  = 2'd0;
          st_nxt  = S_ADIV;
        end
      end
      S_FMUL: st_nxt = S_FADD;
      S_FADD: if (ax_r == 2'd2) begin
        st_nxt = S_IDLE;
      end else begin
        ax_nxt = ax_r + 2'd1;
        st_nxt = S_FMUL;
      end
      S_ADIV: begin
        div_start = 1'b1;
        div_dvd   = {{(32-FRAC_BITS){div_force[31]}}, div_force, {FRAC_BITS{1'b0}}};
        div_dsr   = mass_r[obj_r];
        st_nxt    = S_AWAIT;
      end
      S_AWAIT: if (div_done) st_nxt = S_VEL;
      S_VEL:   st_nxt = S_MMUL;
      S_MMUL:  st_nxt = S_MDIV;
      S_MDIV: begin
        div_start = 1'b1;
        div_dvd   = prod_r;
        div_dsr   = {1'b0, scale_r};
        st_nxt    = S_MWAIT;
      end
      S_MWAIT: if (div_done) st_nxt = S_MPOS;
      S_MPOS: if (ax_r == 2'd2) begin
        ax_nxt  = 2'd0;
        pl_nxt  = '0;
        blk_nxt = 1'b0;
        st_nxt  = (np_w == 4'd0) ? S_OUT : S_CORN;
      end else begin
        ax_nxt = ax_r + 2'd1;
        st_nxt = S_ADIV;
      end
      S_CORN: begin
        crn_nxt = 3'd0;
        ax_nxt  = 2'd0;
        st_nxt  = S_DMUL;
      end
      S_DMUL: st_nxt = S_DACC;
      S_DACC: if (ax_r != 2'd2) begin
        ax_nxt = ax_r + 2'd1;
        st_nxt = S_DMUL;
      end else begin
        ax_nxt = 2'd0;
        if (acc_sum[ACC_W-1]) begin
          hit     = 1'b1;
          blk_nxt = 1'b1;
        end
        if (acc_sum[ACC_W-1] || crn_r == 3'd7) begin
          if (pl_last) begin
            st_nxt = S_OUT;
          end else begin
            pl_nxt = pl_r + 1'b1;
            st_nxt = S_CORN;
          end
        end else begin
          crn_nxt = crn_r + 3'd1;
          st_nxt  = S_DMUL;
        end
      end
      S_OUT: if (!out_valid_r || out_ready) begin
        out_load = 1'b1;
        if (obj_last) begin
          st_nxt = S_IDLE;
        end else begin
          obj_nxt = obj_r + 1'b1;
          ax_nxt  = 2'd0;
          st_nxt  = S_ADIV;
        end
      end
      default: st_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      case (q_cmd.cmd)
        CMD_SET_POS: pos_r[q_cmd.index] <= q_cmd.vec;
        CMD_SET_VEL: begin
          vel_r[q_cmd.index]  <= q_cmd.vec;
          mass_r[q_cmd.index] <= q_cmd.scalar;
        end
        CMD_BOX_LO: blo_r[q_cmd.index] <= q_cmd.vec;
        CMD_BOX_HI: bhi_r[q_cmd.index] <= q_cmd.vec;
        CMD_SET_PLANE: begin
          nrm_r[q_cmd.index[PLANE_W-1:0]] <= q_cmd.vec;
          off_r[q_cmd.index[PLANE_W-1:0]] <= q_cmd.scalar;
        end
        default: ;
      endcase
    end
    if (st_r == S_VEL) vel_r[obj_r][ax_r] <= vel_new;
    if (st_r == S_MPOS) pos_r[obj_r][ax_r] <= sadd(pos_r[obj_r][ax_r], div_q);
    if (hit) begin
      for (int a = 0; a < 3; a++) pos_r[obj_r][a] <= ssub(pos_r[obj_r][a], mv_r[a]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < MAX_OBJECTS; i++) frc_r[i] <= '0;
    end else begin
      if (pop && q_cmd.cmd == CMD_SET_VEL) frc_r[q_cmd.index] <= '0;
      if (pop && q_cmd.cmd == CMD_SET_FORCE) frc_r[q_cmd.index] <= q_cmd.vec;
      if (st_r == S_FADD) begin
        frc_r[cmd_r.index][ax_r] <= sadd(frc_r[cmd_r.index][ax_r], sat32(prod_sh));
      end
      if (st_r == S_MPOS && ax_r == 2'd2) frc_r[obj_r] <= '0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) cmd_r <= q_cmd;
    if (st_r == S_FMUL) prod_r <= cmd_r.vec[ax_r] * mass_r[cmd_r.index];
    if (st_r == S_MMUL) prod_r <= vel_r[obj_r][ax_r] * $signed({1'b0, ts_r});
    if (st_r == S_DMUL) prod_r <= nrm_r[pl_r][ax_r] * corner;
    if (st_r == S_MPOS) mv_r[ax_r] <= div_q;
    if (st_r == S_CORN) begin
      for (int a = 0; a < 3; a++) begin
        lo_r[a] <= sadd(blo_r[obj_r][a], pos_r[obj_r][a]);
        hi_r[a] <= sadd(bhi_r[obj_r][a], pos_r[obj_r][a]);
      end
      acc_r <= off_ext;
    end
    if (st_r == S_DACC) acc_r <= (ax_r == 2'd2) ? off_ext : acc_sum;
    if (out_load) begin
      out_idx_r  <= obj_r;
      out_pos_r  <= pos_r[obj_r];
      out_blk_r  <= blk_r;
      out_last_r <= obj_last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= S_IDLE;
      ax_r        <= 2'd0;
      obj_r       <= '0;
      pl_r        <= '0;
      crn_r       <= 3'd0;
      blk_r       <= 1'b0;
      out_valid_r <= 1'b0;
      grav_r      <= '0;
      ts_r        <= 31'd1092;
      scale_r     <= 31'd65536;
      ocnt_r      <= 5'd0;
      pcnt_r      <= 4'd0;
    end else begin
      st_r  <= st_nxt;
      ax_r  <= ax_nxt;
      obj_r <= obj_nxt;
      pl_r  <= pl_nxt;
      crn_r <= crn_nxt;
      blk_r <= blk_nxt;
      if (out_load) out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
      if (cfg_we) begin
        case (cfg_index)
          CFG_GRAV_X:    grav_r[0] <= cfg_data;
          CFG_GRAV_Y:    grav_r[1] <= cfg_data;
          CFG_GRAV_Z:    grav_r[2] <= cfg_data;
          CFG_TIME_STEP: ts_r      <= cfg_data[30:0];
          CFG_SCALE:     scale_r   <= cfg_data[30:0];
          CFG_OBJ_CNT:   ocnt_r    <= cfg_data[4:0];
          CFG_PLANE_CNT: pcnt_r    <= cfg_data[3:0];
          default: ;
        endcase
      end
    end
  end

  assign out_valid        = out_valid_r;
  assign out_object_index = out_idx_r;
  assign out_pos          = out_pos_r;
  assign out_blocked      = out_blk_r;
  assign out_last         = out_last_r;

`ifndef ASSERT_OFF
  a_div_idle: assert property (@(posedge clk) disable iff (!rst_n)
    div_start |-> !div_busy) else $error("divider started while busy");
  a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_load && obj_last |=> st_r == S_IDLE) else $error("step did not end on last beat");
  a_fadd_seq: assert property (@(posedge clk) disable iff (!rst_n)
    st_r == S_FADD |-> $past(st_r) == S_FMUL) else $error("force add without product");
`endif

endmodule
`default_nettype wire

[rtl/core/rigid_body_euler_step_plane_collide.sv]
// Top level: explicit Euler step of up to 16 boxes with plane collision, Q16.16.
//
// Command beats enter on in_* (valid/ready); each step command (cmd 7) yields
// one beat per stepped object on out_*, in index order, with out_last on the
// final one. Other commands yield no beat. Registers are written on cfg_* with
// cfg_we; the user must do so only while no command is in flight (not enforced).
// A two-entry queue sits between the front end and the sequencer, so up to
// two commands are queued while a step runs. Table writes are done in the
// idle state; an add-acceleration command runs a product and an add per axis.
// Per object a step runs six divisions on the shared radix-2 divider (three
// for force/mass, three for movement), adds and products, an output state,
// and a product and an accumulate state per term, up to 24 terms for each
// plane test.
// Reset (rst_n low, synchronous) clears forces, config and control; other
// tables hold garbage until written. When out_ready is low the result
// register holds its beat and the sequencer waits in its output state.
`default_nettype none
module rigid_body_euler_step_plane_collide
  import rbes_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [31:0]          cfg_data,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire logic [2:0]           in_cmd,
  input  wire logic [OBJ_W-1:0]     in_index,
  input  wire q_t                   in_vec_x,
  input  wire q_t                   in_vec_y,
  input  wire q_t                   in_vec_z,
  input  wire q_t                   in_scalar,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output logic [OBJ_W-1:0]          out_object_index,
  output q_t                        out_pos_x,
  output q_t                        out_pos_y,
  output q_t                        out_pos_z,
  output logic                      out_blocked,
  output logic                      out_last
);

  logic  q_valid, q_ready;
  cmd_t  q_cmd;
  vec3_t pos;

  rbes_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_cmd    (in_cmd),
    .in_index  (in_index),
    .in_vec_x  (in_vec_x),
    .in_vec_y  (in_vec_y),
    .in_vec_z  (in_vec_z),
    .in_scalar (in_scalar),
    .q_valid   (q_valid),
    .q_ready   (q_ready),
    .q_cmd     (q_cmd)
  );

  rbes_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .q_valid          (q_valid),
    .q_ready          (q_ready),
    .q_cmd            (q_cmd),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_object_index (out_object_index),
    .out_pos          (pos),
    .out_blocked      (out_blocked),
    .out_last         (out_last)
  );

  assign out_pos_x = pos[0];
  assign out_pos_y = pos[1];
  assign out_pos_z = pos[2];

endmodule
`default_nettype wire

[tb/sv/tb.sv]
// Testbench for the rigid body Euler step block: directed table, random phases, scoreboard.
`default_nettype none
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import rbes_pkg::q_t;
  import rbes_pkg::CMD_SET_POS;
  import rbes_pkg::CMD_SET_VEL;
  import rbes_pkg::CMD_BOX_LO;
  import rbes_pkg::CMD_BOX_HI;
  import rbes_pkg::CMD_SET_FORCE;
  import rbes_pkg::CMD_ADD_ACC;
  import rbes_pkg::CMD_SET_PLANE;
  import rbes_pkg::CMD_STEP;
  import rbes_pkg::CFG_GRAV_X;
  import rbes_pkg::CFG_GRAV_Y;
  import rbes_pkg::CFG_GRAV_Z;
  import rbes_pkg::CFG_TIME_STEP;
  import rbes_pkg::CFG_SCALE;
  import rbes_pkg::CFG_OBJ_CNT;
  import rbes_pkg::CFG_PLANE_CNT;

  localparam int  N_OBJ      = 16;
  localparam int  N_PLANE    = 8;
  localparam int  IDLE_LIMIT = 40000;
  localparam int  HOLD_LEN   = 3000;
  localparam int  SETTLE     = 100;
  localparam q_t  Q_MAX      = 32'sh7fffffff;
  localparam q_t  Q_MIN      = 32'sh80000000;
  localparam q_t  Q_ONE      = 32'sh00010000;
  localparam logic [2:0] CFG_UNUSED = 3'd7;

  typedef struct packed {
    logic [3:0] idx;
    q_t         x;
    q_t         y;
    q_t         z;
    logic       blk;
    logic       last;
  } pos_beat_t;

  typedef struct {
    logic [2:0] cmd;
    logic [3:0] idx;
    q_t         x, y, z, s;
    bit         typed;
    pos_beat_t  want;
  } cmd_row_t;

  logic clk, rst_n;
  logic cfg_we;
  logic [2:0] cfg_index;
  logic [31:0] cfg_data;
  logic in_valid, in_ready;
  logic [2:0] in_cmd;
  logic [3:0] in_index;
  q_t in_vec_x, in_vec_y, in_vec_z, in_scalar;
  logic out_valid, out_ready;
  logic [3:0] out_object_index;
  q_t out_pos_x, out_pos_y, out_pos_z;
  logic out_blocked, out_last;

  rigid_body_euler_step_plane_collide u_dut (
    .clk(clk), .rst_n(rst_n),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready), .in_cmd(in_cmd), .in_index(in_index),
    .in_vec_x(in_vec_x), .in_vec_y(in_vec_y), .in_vec_z(in_vec_z),
    .in_scalar(in_scalar),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_object_index(out_object_index),
    .out_pos_x(out_pos_x), .out_pos_y(out_pos_y), .out_pos_z(out_pos_z),
    .out_blocked(out_blocked), .out_last(out_last)
  );

  always begin
    clk = 1'b1; #10;
    clk = 1'b0; #10;
  end

  // shadow state of the block
  q_t obj_pos [N_OBJ][3];
  q_t obj_vel [N_OBJ][3];
  q_t obj_frc [N_OBJ][3];
  q_t obj_mass [N_OBJ];
  q_t box_lo [N_OBJ][3];
  q_t box_hi [N_OBJ][3];
  q_t pl_norm [N_PLANE][3];
  q_t pl_off [N_PLANE];
  q_t grav [3];
  longint tstep, cscale;
  int n_obj_cfg, n_pl_cfg;

  pos_beat_t pending_pos [$];
  cmd_row_t  cmd_table [$];
  int errors, items, beats, steps, blocked_beats, burst_left;
  bit hold_req, hold_done;
  int hold_cnt, rx_mode, rx_cnt, idle_cycles;

  function automatic q_t clamp32(longint v);
    if (v > longint'(Q_MAX)) return Q_MAX;
    if (v < longint'(Q_MIN)) return Q_MIN;
    return q_t'(v);
  endfunction

  function automatic q_t sat_add(q_t a, q_t b);
    return clamp32(longint'(a) + longint'(b));
  endfunction

  function automatic q_t sat_sub(q_t a, q_t b);
    return clamp32(longint'(a) - longint'(b));
  endfunction

  function automatic longint floor16(longint p);
    return p >>> 16;
  endfunction

  function automatic q_t force_accel(q_t f, q_t m);
    if (m == 0) return 0;
    return clamp32((longint'(f) * 65536) / longint'(m));
  endfunction

  function automatic q_t movement(q_t v);
    if (cscale == 0) return 0;
    return clamp32((longint'(v) * tstep) / cscale);
  endfunction

  function automatic bit plane_blocks(int p, int o);
    q_t lo [3];
    q_t hi [3];
    q_t c;
    longint acc;
    for (int a = 0; a < 3; a++) begin
      lo[a] = sat_add(box_lo[o][a], obj_pos[o][a]);
      hi[a] = sat_add(box_hi[o][a], obj_pos[o][a]);
    end
    for (int k = 0; k < 8; k++) begin
      acc = longint'(pl_off[p]);
      for (int a = 0; a < 3; a++) begin
        c = ((k >> a) & 1) ? hi[a] : lo[a];
        acc += floor16(longint'(pl_norm[p][a]) * longint'(c));
      end
      if (acc < 0) return 1;
    end
    return 0;
  endfunction

  task automatic integrate_cmd(logic [2:0] cmd, logic [3:0] idx, q_t x, q_t y, q_t z, q_t s);
    q_t v [3];
    q_t acc, mv [3];
    int n, np;
    bit blk;
    pos_beat_t pb;
    v[0] = x; v[1] = y; v[2] = z;
    case (cmd)
      CMD_STEP: begin
        n = (n_obj_cfg > N_OBJ) ? N_OBJ : n_obj_cfg;
        np = (n_pl_cfg > N_PLANE) ? N_PLANE : n_pl_cfg;
        steps++;
        for (int o = 0; o < n; o++) begin
          for (int a = 0; a < 3; a++) begin
            acc = sat_add(force_accel(obj_frc[o][a], obj_mass[o]), grav[a]);
            obj_frc[o][a] = 0;
            obj_vel[o][a] = sat_add(obj_vel[o][a], acc);
            mv[a] = movement(obj_vel[o][a]);
            obj_pos[o][a] = sat_add(obj_pos[o][a], mv[a]);
          end
          blk = 0;
          for (int p = 0; p < np; p++) begin
            if (plane_blocks(p, o)) begin
              for (int a = 0; a < 3; a++) obj_pos[o][a] = sat_sub(obj_pos[o][a], mv[a]);
              blk = 1;
            end
          end
          pb = '{4'(o), obj_pos[o][0], obj_pos[o][1], obj_pos[o][2], blk, o == n - 1};
          pending_pos = {pending_pos, pb};
        end
      end
      CMD_SET_PLANE: begin
        if (idx < N_PLANE) begin
          pl_norm[idx] = v;
          pl_off[idx] = s;
        end
      end
      CMD_SET_POS: obj_pos[idx] = v;
      CMD_SET_VEL: begin
        obj_vel[idx] = v;
        obj_mass[idx] = s;
        for (int a = 0; a < 3; a++) obj_frc[idx][a] = 0;
      end
      CMD_BOX_LO: box_lo[idx] = v;
      CMD_BOX_HI: box_hi[idx] = v;
      CMD_SET_FORCE: obj_frc[idx] = v;
      CMD_ADD_ACC: begin
        for (int a = 0; a < 3; a++)
          obj_frc[idx][a] = sat_add(obj_frc[idx][a],
                                    clamp32(floor16(longint'(v[a]) * longint'(obj_mass[idx]))));
      end
      default: ;
    endcase
  endtask

  task automatic report(string what);
    $display("mismatch @%0t: %s", $realtime, what);
    errors++;
  endtask

  task automatic cfg_write(logic [2:0] idx, logic [31:0] data);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
    case (idx)
      CFG_GRAV_X: grav[0] = q_t'(data);
      CFG_GRAV_Y: grav[1] = q_t'(data);
      CFG_GRAV_Z: grav[2] = q_t'(data);
      CFG_TIME_STEP: tstep = longint'(data[30:0]);
      CFG_SCALE: cscale = longint'(data[30:0]);
      CFG_OBJ_CNT: n_obj_cfg = int'(data[4:0]);
      CFG_PLANE_CNT: n_pl_cfg = int'(data[3:0]);
      default: ;
    endcase
  endtask

  task automatic set_phase(q_t gx, q_t gy, q_t gz, logic [31:0] ts, logic [31:0] cs,
                           int oc, int pc);
    cfg_write(CFG_GRAV_X, gx);
    cfg_write(CFG_GRAV_Y, gy);
    cfg_write(CFG_GRAV_Z, gz);
    cfg_write(CFG_TIME_STEP, ts);
    cfg_write(CFG_SCALE, cs);
    cfg_write(CFG_OBJ_CNT, 32'(oc));
    cfg_write(CFG_PLANE_CNT, 32'(pc));
  endtask

  // called at a falling edge, returns at a falling edge
  task automatic send_beat(logic [2:0] cmd, logic [3:0] idx, q_t x, q_t y, q_t z, q_t s);
    if (burst_left == 0) begin
      if ($urandom_range(0, 3) != 0) begin
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 12)) @(negedge clk);
      end
      burst_left = $urandom_range(1, 16);
    end
    burst_left--;
    in_valid <= 1'b1;
    in_cmd <= cmd;
    in_index <= idx;
    in_vec_x <= x;
    in_vec_y <= y;
    in_vec_z <= z;
    in_scalar <= s;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    integrate_cmd(cmd, idx, x, y, z, s);
    items++;
    @(negedge clk);
  endtask

  task automatic drain;
    in_valid <= 1'b0;
    while (pending_pos.size() != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  function automatic q_t small_q();
    return q_t'($urandom_range(0, 8 << 16)) - (4 <<< 16);
  endfunction

  function automatic q_t rand_q();
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4: return small_q();
      5, 6, 7: return q_t'($urandom);
      default: begin
        case ($urandom_range(0, 3))
          0: return Q_MAX;
          1: return Q_MIN;
          2: return 0;
          default: return -1;
        endcase
      end
    endcase
  endfunction

  task automatic row(logic [2:0] cmd, logic [3:0] idx, q_t x, q_t y, q_t z, q_t s,
                     bit typed = 0, pos_beat_t want = '0);
    cmd_row_t r;
    r.cmd = cmd; r.idx = idx; r.x = x; r.y = y; r.z = z; r.s = s;
    r.typed = typed; r.want = want;
    cmd_table = {cmd_table, r};
  endtask

  task automatic random_item();
    logic [2:0] cmd;
    logic [3:0] idx;
    int r;
    r = $urandom_range(0, 99);
    cmd = (r < 12) ? CMD_STEP : 3'($urandom_range(0, 6));
    idx = 4'($urandom_range(0, 15));
    if (cmd == CMD_SET_PLANE && $urandom_range(0, 4) != 0)
      send_beat(cmd, idx, $urandom_range(0, 1) ? Q_ONE : -Q_ONE,
                $urandom_range(0, 2) == 0 ? small_q() : 0, small_q() >>> 2,
                small_q() <<< 3);
    else if (cmd == CMD_BOX_LO && $urandom_range(0, 3) != 0)
      send_beat(cmd, idx, -(small_q() & 32'h3ffff), -(small_q() & 32'h3ffff),
                -(small_q() & 32'h3ffff), rand_q());
    else if (cmd == CMD_BOX_HI && $urandom_range(0, 3) != 0)
      send_beat(cmd, idx, small_q() & 32'h3ffff, small_q() & 32'h3ffff,
                small_q() & 32'h3ffff, rand_q());
    else
      send_beat(cmd, idx, rand_q(), rand_q(), rand_q(), rand_q());
  endtask

  // receiver: rotating stall patterns plus one long hold-off on request
  always @(negedge clk) begin
    rx_cnt <= rx_cnt + 1;
    if (rx_cnt % 700 == 699) rx_mode <= $urandom_range(0, 2);
    if (hold_req && !hold_done) begin
      out_ready <= 1'b0;
      hold_cnt = hold_cnt + 1;
      if (hold_cnt >= HOLD_LEN) hold_done = 1;
    end else begin
      case (rx_mode)
        0: out_ready <= 1'b1;
        1: out_ready <= ($urandom_range(0, 1) == 1);
        default: out_ready <= (rx_cnt % 7) < 4;
      endcase
    end
  end

  always @(posedge clk) begin
    pos_beat_t want;
    if (rst_n && out_valid && out_ready) begin
      beats++;
      if (pending_pos.size() == 0) begin
        report($sformatf("unexpected beat for object %0d", out_object_index));
      end else begin
        want = pending_pos.pop_front();
        if (out_blocked) blocked_beats++;
        if (out_object_index !== want.idx)
          report($sformatf("object_index %0d, want %0d", out_object_index, want.idx));
        if (out_pos_x !== want.x)
          report($sformatf("obj %0d pos_x %h, want %h", want.idx, out_pos_x, want.x));
        if (out_pos_y !== want.y)
          report($sformatf("obj %0d pos_y %h, want %h", want.idx, out_pos_y, want.y));
        if (out_pos_z !== want.z)
          report($sformatf("obj %0d pos_z %h, want %h", want.idx, out_pos_z, want.z));
        if (out_blocked !== want.blk)
          report($sformatf("obj %0d blocked %b, want %b", want.idx, out_blocked, want.blk));
        if (out_last !== want.last)
          report($sformatf("obj %0d last %b, want %b", want.idx, out_last, want.last));
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("timeout: no beat for %0d cycles", IDLE_LIMIT);
      $display("tb: FAIL");
      $finish;
    end
  end

  initial begin
    cmd_row_t r;
    rst_n = 1'b0;
    cfg_we = 1'b0; cfg_index = '0; cfg_data = '0;
    in_valid = 1'b0; in_cmd = '0; in_index = '0;
    in_vec_x = 0; in_vec_y = 0; in_vec_z = 0; in_scalar = 0;
    out_ready = 1'b0;
    hold_req = 0; hold_done = 0; hold_cnt = 0; rx_mode = 0; rx_cnt = 0; idle_cycles = 0;
    errors = 0; items = 0; beats = 0; steps = 0; blocked_beats = 0; burst_left = 0;
    grav[0] = 0; grav[1] = 0; grav[2] = 0;
    tstep = 1092; cscale = 65536; n_obj_cfg = 0; n_pl_cfg = 0;
    for (int o = 0; o < N_OBJ; o++)
      for (int a = 0; a < 3; a++) begin
        obj_pos[o][a] = 0; obj_vel[o][a] = 0; obj_frc[o][a] = 0;
        box_lo[o][a] = 0; box_hi[o][a] = 0;
      end
    for (int o = 0; o < N_OBJ; o++) obj_mass[o] = 0;
    for (int p = 0; p < N_PLANE; p++) begin
      pl_off[p] = 0;
      for (int a = 0; a < 3; a++) pl_norm[p][a] = 0;
    end
    repeat (4) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // every table entry a step can read gets written first
    for (int o = 0; o < N_OBJ; o++) begin
      send_beat(CMD_SET_POS, 4'(o), small_q(), small_q(), small_q(), 0);
      send_beat(CMD_SET_VEL, 4'(o), small_q(), small_q(), small_q(), Q_ONE + small_q());
      send_beat(CMD_BOX_LO, 4'(o), -Q_ONE, -Q_ONE, -Q_ONE, 0);
      send_beat(CMD_BOX_HI, 4'(o), Q_ONE, Q_ONE, Q_ONE, 0);
    end
    for (int p = 0; p < N_PLANE; p++)
      send_beat(CMD_SET_PLANE, 4'(p), 0, 0, Q_ONE, 20 <<< 16);
    drain();

    // directed
    set_phase(0, 0, 0, 1092, 65536, 1, 1);
    cfg_write(CFG_UNUSED, 32'hdeadbeef);
    row(CMD_SET_POS, 0, Q_MAX, Q_MIN, 0, 0);
    row(CMD_SET_VEL, 0, 0, 0, 0, 0);
    row(CMD_SET_PLANE, 0, 0, 0, 0, 0);
    row(CMD_STEP, 0, 0, 0, 0, 0, 1, '{4'd0, Q_MAX, Q_MIN, 32'sd0, 1'b0, 1'b1});
    row(CMD_SET_PLANE, 0, 0, 0, 0, -1);
    row(CMD_STEP, 0, 0, 0, 0, 0, 1, '{4'd0, Q_MAX, Q_MIN, 32'sd0, 1'b1, 1'b1});
    row(CMD_SET_PLANE, 9, Q_MAX, Q_MAX, Q_MAX, Q_MIN);
    row(CMD_SET_PLANE, 15, Q_MIN, Q_MIN, Q_MIN, Q_MAX);
    row(CMD_SET_POS, 0, 0, 0, 0, 0);
    row(CMD_SET_VEL, 0, Q_ONE, -Q_ONE, Q_MAX, Q_ONE);
    row(CMD_SET_FORCE, 0, Q_MIN, Q_MAX, 12345, 0);
    row(CMD_ADD_ACC, 0, Q_MAX, Q_MIN, -1, 0);
    row(CMD_SET_PLANE, 0, 0, 0, Q_ONE, 0);
    row(CMD_BOX_LO, 0, Q_MIN, Q_MIN, Q_MIN, 0);
    row(CMD_BOX_HI, 0, Q_MAX, Q_MAX, Q_MAX, 0);
    row(CMD_STEP, 0, 0, 0, 0, 0);
    row(CMD_SET_VEL, 0, 5 <<< 16, 0, -(3 <<< 16), 0);
    row(CMD_SET_FORCE, 0, 7 <<< 16, -(7 <<< 16), 1, 0);
    row(CMD_STEP, 0, 0, 0, 0, 0);
    row(CMD_SET_VEL, 0, 0, Q_ONE, 0, -(2 <<< 16));
    row(CMD_ADD_ACC, 0, 3 <<< 16, -Q_ONE, Q_MAX, 0);
    row(CMD_SET_PLANE, 0, Q_ONE, Q_ONE, Q_ONE, -(100 <<< 16));
    row(CMD_STEP, 0, 0, 0, 0, 0);
    row(CMD_SET_POS, 0, Q_MAX, Q_MAX, Q_MIN, 0);
    row(CMD_STEP, 0, 0, 0, 0, 0);
    foreach (cmd_table[i]) begin
      r = cmd_table[i];
      send_beat(r.cmd, r.idx, r.x, r.y, r.z, r.s);
      if (r.typed) pending_pos[pending_pos.size() - 1] = r.want;
    end
    drain();

    // random phases; count and plane extremes, scale and time step corners
    for (int ph = 0; ph < 8; ph++) begin
      case (ph)
        0: set_phase(small_q(), small_q(), small_q(), 1092, 65536, 3, 2);
        1: set_phase(0, 0, 0, 0, 65536, 4, 8);
        2: set_phase(Q_MIN, Q_MAX, -1, 32'h7fffffff, 1, 2, 1);
        3: set_phase(small_q(), small_q(), small_q(), 65536, 0, 16, 0);
        4: set_phase(rand_q(), rand_q(), rand_q(), $urandom_range(0, 1 << 20),
                     32'h7fffffff, 0, 3);
        5: set_phase(small_q(), small_q(), small_q(), 4096, 65536, 31, 15);
        default: set_phase(small_q(), small_q(), small_q(), $urandom_range(0, 1 << 18),
                           $urandom_range(1, 1 << 18), $urandom_range(1, 5),
                           $urandom_range(0, 4));
      endcase
      if (ph == 1) hold_req = 1;
      for (int i = 0; i < 27; i++) random_item();
      send_beat(CMD_STEP, 0, 0, 0, 0, 0);
      drain();
    end

    repeat (200) @(negedge clk);
    $display("run: %0d command beats, %0d steps, %0d position beats (%0d blocked)",
             items, steps, beats, blocked_beats);
    $display("     8 random config phases incl. count clamps, zero scale, long output stall");
    if (errors == 0 && pending_pos.size() == 0) begin
      $display("tb: PASS");
    end else begin
      $display("errors %0d, beats still owed %0d", errors, pending_pos.size());
      $display("tb: FAIL");
    end
    $finish;
  end

endmodule
`default_nettype wire

[filelist.f]
rtl/core/rbes_pkg.sv
rtl/core/rbes_front.sv
rtl/core/rbes_div.sv
rtl/core/rbes_back.sv
rtl/core/rigid_body_euler_step_plane_collide.sv
tb/sv/tb.sv
